FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the cache lookup RTL.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

FILE: rtl/core/dmc_pkg.sv
// Shared constants, types and store request/response structs for the cache lookup.
// No dependencies.
`default_nettype none

package dmc_pkg;

  localparam int ENTRIES      = 16;
  localparam int ADDRESS_BITS = 16;
  localparam int DATA_BITS    = 32;
  localparam int INDEX_OUT_W  = 4;

  // Entry count register.
  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  // The count register cannot name more than this many entries.
  localparam int CFG_MAX      = (1 << CFG_W) - 1;
  localparam int USED_ENTRIES = (ENTRIES < CFG_MAX) ? ENTRIES : CFG_MAX;
  localparam int IDX_W        = (USED_ENTRIES > 1) ? $clog2(USED_ENTRIES) : 1;

  // Partial remainder needs one bit above the divisor.
  localparam int REM_W = CFG_W + 1;
  localparam int STEP_W = $clog2(ADDRESS_BITS + 1);

  typedef enum logic [1:0] {
    OUTCOME_EMPTY    = 2'd0,
    OUTCOME_HIT      = 2'd1,
    OUTCOME_CONFLICT = 2'd2
  } outcome_t;

  typedef struct packed {
    logic                    rd;
    logic                    wr;
    logic [IDX_W-1:0]        idx;
    logic [ADDRESS_BITS-1:0] tag;
    logic [DATA_BITS-1:0]    word;
  } store_req_t;

  typedef struct packed {
    logic                    valid;
    logic [ADDRESS_BITS-1:0] tag;
    logic [DATA_BITS-1:0]    word;
  } store_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/direct_mapped_cache_lookup.sv
// Top level of the direct-mapped cache lookup: sequencer, count register, assertions.
// Depends on dmc_pkg, dmc_remainder, dmc_store and assert_macros.svh.
//
// Usage:
//   An access (address, fill_data) transfers at a rising edge with start high
//   and busy low. The entry index is address modulo entries_in_use (0 counts
//   as 1, values above the entry count are clamped). The result (outcome,
//   entry_index, read_data) is on the ports for exactly one cycle with done
//   high; the receiver cannot stall it, so it must take it in that cycle.
//   The transfer starts the bit-serial remainder unit (one address bit per
//   cycle); a tag read, a compare-and-fill write and a read-back of the
//   entry through the single memory port follow, and done rises with the
//   read-back. busy drops in the done cycle, so a new access can transfer
//   at the edge that ends it; before that, start is ignored.
//   cfg_we writes entries_in_use from cfg_wdata; write it only while idle.
//   Reset (synchronous, rst high) clears all valid flags at once, sets
//   entries_in_use to 16 and returns the block to idle; tags and data stay
//   undefined until filled.
`default_nettype none

`include "assert_macros.svh"

module direct_mapped_cache_lookup (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [dmc_pkg::ADDRESS_BITS-1:0] address,
  input  wire logic [dmc_pkg::DATA_BITS-1:0]    fill_data,
  output logic                                  done,
  output dmc_pkg::outcome_t                     outcome,
  output logic [dmc_pkg::INDEX_OUT_W-1:0]       entry_index,
  output logic [dmc_pkg::DATA_BITS-1:0]         read_data,
  input  wire logic                             cfg_we,
  input  wire logic [dmc_pkg::CFG_W-1:0]        cfg_wdata
);
  import dmc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVIDE,
    S_TAG_READ,
    S_COMPARE,
    S_READBACK
  } state_t;

  state_t                  state;
  logic [CFG_W-1:0]        entries_in_use;
  logic [CFG_W-1:0]        n_eff;
  logic [ADDRESS_BITS-1:0] addr_q;
  logic [DATA_BITS-1:0]    data_q;
  logic [IDX_W-1:0]        idx_q;
  logic                    accept;
  logic                    div_done;
  logic [REM_W-1:0]        div_rem;
  outcome_t                lookup_outcome;
  store_req_t              req;
  store_rsp_t              rsp;

  assign accept = start && !busy;

  // Clamp the count register: zero means one entry, and never past the store depth.
  always_comb begin
    if (entries_in_use == '0) begin
      n_eff = CFG_W'(1);
    end else if (entries_in_use > CFG_W'(USED_ENTRIES)) begin
      n_eff = CFG_W'(USED_ENTRIES);
    end else begin
      n_eff = entries_in_use;
    end
  end

  // Count register; the user must write it only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= CFG_RESET;
    end else if (cfg_we) begin
      entries_in_use <= cfg_wdata;
    end
  end

  // Remainder unit starts on the same edge that transfers the access.
  dmc_remainder u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (address),
    .divisor  (n_eff),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Tag read, then fill, then read back the filled word through one port.
  always_comb begin
    req.rd   = (state == S_TAG_READ) || (state == S_READBACK);
    req.wr   = (state == S_COMPARE);
    req.idx  = idx_q;
    req.tag  = addr_q;
    req.word = data_q;
  end

  dmc_store u_store (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Classify against the entry as it stood before the fill.
  always_comb begin
    if (!rsp.valid) begin
      lookup_outcome = OUTCOME_EMPTY;
    end else if (rsp.tag == addr_q) begin
      lookup_outcome = OUTCOME_HIT;
    end else begin
      lookup_outcome = OUTCOME_CONFLICT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            // Hold the access for the whole lookup.
            addr_q <= address;
            data_q <= fill_data;
            busy   <= 1'b1;
            state  <= S_DIVIDE;
          end
        end
        S_DIVIDE: begin
          if (div_done) begin
            idx_q <= IDX_W'(div_rem);
            state <= S_TAG_READ;
          end
        end
        S_TAG_READ: begin
          state <= S_COMPARE;
        end
        S_COMPARE: begin
          outcome <= lookup_outcome;
          state   <= S_READBACK;
        end
        S_READBACK: begin
          // Present the result for one cycle; the read-back word lands with it.
          done        <= 1'b1;
          entry_index <= INDEX_OUT_W'(idx_q);
          busy        <= 1'b0;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign read_data = rsp.word;

  // A transferred access always makes the block busy.
  `ASSERT_NEXT(a_accept_busy, accept, busy)
  // The read-back word matches the fill data of the access being answered.
  `ASSERT_IMPLIES(a_readback_data, done, read_data == data_q)
  // The remainder finishes only while the sequencer waits for it.
  `ASSERT_IMPLIES(a_div_in_divide, div_done, state == S_DIVIDE)
  // Results never come in consecutive cycles.
  `ASSERT_NEXT(a_single_done, done, !done)

endmodule

`default_nettype wire

FILE: rtl/core/dmc_remainder.sv
// Bit-serial restoring remainder: one address bit per cycle.
// Depends on dmc_pkg.
`default_nettype none

module dmc_remainder (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [dmc_pkg::ADDRESS_BITS-1:0] dividend,
  input  wire logic [dmc_pkg::CFG_W-1:0]        divisor,
  output logic                                  done,
  output logic [dmc_pkg::REM_W-1:0]             rem
);
  import dmc_pkg::*;

  logic                    active;
  logic [STEP_W-1:0]       steps;
  logic [ADDRESS_BITS-1:0] shift;
  logic [CFG_W-1:0]        div_q;
  logic [REM_W-1:0]        trial;

  // Shift in the next dividend bit; the partial remainder stays below the divisor.
  assign trial = {rem[REM_W-2:0], shift[ADDRESS_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      steps  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        steps  <= STEP_W'(ADDRESS_BITS);
        shift  <= dividend;
        div_q  <= divisor;
        rem    <= '0;
      end else if (active) begin
        if (trial >= {1'b0, div_q}) begin
          rem <= trial - {1'b0, div_q};
        end else begin
          rem <= trial;
        end
        shift <= shift << 1;
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dmc_store.sv
// Tag and data memory with per-entry valid flags and one registered read port.
// Depends on dmc_pkg.
`default_nettype none

module dmc_store (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dmc_pkg::store_req_t req,
  output dmc_pkg::store_rsp_t      rsp
);
  import dmc_pkg::*;

  logic [ADDRESS_BITS-1:0] tag_mem  [USED_ENTRIES];
  logic [DATA_BITS-1:0]    word_mem [USED_ENTRIES];
  logic [USED_ENTRIES-1:0] valid;
  logic                    rd_valid;
  logic [ADDRESS_BITS-1:0] rd_tag;
  logic [DATA_BITS-1:0]    rd_word;

  assign rsp = '{valid: rd_valid, tag: rd_tag, word: rd_word};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.wr) begin
        valid[req.idx] <= 1'b1;
      end
      if (req.rd) begin
        rd_valid <= valid[req.idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr) begin
      tag_mem[req.idx]  <= req.tag;
      word_mem[req.idx] <= req.word;
    end
    if (req.rd) begin
      rd_tag  <= tag_mem[req.idx];
      rd_word <= word_mem[req.idx];
    end
  end

endmodule

`default_nettype wire
